[sv/whss_pkg.sv]
// Shared types and constants for the wave height stencil step unit.
`default_nettype none

package whss_pkg;

	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;

	localparam int H_W        = 32;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int POS_W      = 8;
	localparam int FIFO_DEPTH = 8;

	localparam int                ROWS_RESET = 256;
	localparam int                COLS_RESET = 256;
	localparam logic [COEF_W-1:0] BETA_RESET = 16'd58982;
	localparam logic [COEF_W-1:0] GAIN_RESET = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_BETA = 2'd2,
		REG_GAIN = 2'd3
	} cfg_reg_t;

	// One cell update: centre, the four neighbours (zero when missing), the
	// number of neighbours present, previous height, position tag and done flag.
	typedef struct packed {
		logic signed [H_W-1:0] h;
		logic signed [H_W-1:0] nb_l;
		logic signed [H_W-1:0] nb_r;
		logic signed [H_W-1:0] nb_u;
		logic signed [H_W-1:0] nb_d;
		logic [2:0]            nb_cnt;
		logic signed [H_W-1:0] prev;
		logic [POS_W-1:0]      row;
		logic [POS_W-1:0]      col;
		logic                  done;
	} job_t;

	typedef struct packed {
		logic [H_W-1:0]   height;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} res_t;

endpackage

`default_nettype wire

[sv/wave_height_stencil_step_unit.sv]
// Damped wave height update over a streamed grid with a five-point stencil.
//
// Cells enter on the s_ channel in row-major order, one transaction per cell,
// carrying the current and previous height. Results leave on the m_ channel:
// a cell of row r-1 is produced once row r has reached its column, and the
// last row is finished while it streams in; m_tlast marks the grid's final
// cell. Grid size, damping and gain are written on the cfg_ port while idle;
// a size write restarts the grid at row 0, column 0.
// Throughput, while the output queue has room: one cell per cycle in every row
// but the last, where each cell but the first yields two results and the input
// is paced to one result per cycle; the final cell yields three. The pace is
// set by the single arithmetic pipeline, which takes one cell update per cycle.
// A result is offered once the transaction that completes its neighbourhood
// has passed the input stage, calculation stages s1 to s5 and the output queue.
// Results wait in an eight-entry output queue. New cell updates start only
// while a queue slot is reserved for them, so a stalled receiver fills the
// queue and then holds s_tready low; nothing is dropped.
// Reset clears position, size and coefficients to their defaults and empties
// the queue; the line memories need no clearing pass.
`default_nettype none

module wave_height_stencil_step_unit #(
	parameter int MAX_ROWS = whss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = whss_pkg::MAX_COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,   // height_now, height_before
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,   // new_height, out_row, out_col
	output logic                            m_tlast,   // grid_done
	input  logic                            cfg_write,
	input  logic [whss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [whss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import whss_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = $clog2(MAX_COLS);
	localparam int HA_W  = $clog2(3 * MAX_COLS);
	localparam int PA_W  = $clog2(2 * MAX_COLS);
	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [HA_W-1:0] HSTRIDE = HA_W'(MAX_COLS);
	localparam logic [PA_W-1:0] PSTRIDE = PA_W'(MAX_COLS);

	function automatic logic [12:0] clamp_last(logic [8:0] v, int lim);
		logic [12:0] r;
		if (v == 9'd0) begin
			r = 13'd0;
		end else if (13'(v) > 13'(lim)) begin
			r = 13'(lim) - 13'd1;
		end else begin
			r = 13'(v) - 13'd1;
		end
		return r;
	endfunction

	function automatic logic [HA_W-1:0] haddr(logic [1:0] slot, logic [CW-1:0] col);
		return HA_W'(slot) * HSTRIDE + HA_W'(col);
	endfunction

	function automatic job_t make_job(
		logic signed [H_W-1:0] h,
		logic signed [H_W-1:0] l, logic pl,
		logic signed [H_W-1:0] r, logic pr,
		logic signed [H_W-1:0] u, logic pu,
		logic signed [H_W-1:0] d, logic pd,
		logic signed [H_W-1:0] prev,
		logic [POS_W-1:0] row, logic [POS_W-1:0] col, logic done);
		job_t j;
		j.h      = h;
		j.nb_l   = pl ? l : '0;
		j.nb_r   = pr ? r : '0;
		j.nb_u   = pu ? u : '0;
		j.nb_d   = pd ? d : '0;
		j.nb_cnt = 3'(pl) + 3'(pr) + 3'(pu) + 3'(pd);
		j.prev   = prev;
		j.row    = row;
		j.col    = col;
		j.done   = done;
		return j;
	endfunction

	// Three rows of current heights and two rows of previous heights.
	logic [H_W-1:0] hmem [3 * MAX_COLS];
	logic [H_W-1:0] pmem [2 * MAX_COLS];

	logic [RW-1:0]     last_row_q, row_q;
	logic [CW-1:0]     last_col_q, col_q;
	logic [COEF_W-1:0] beta_q, gain_q;
	logic [1:0]        slot_q, slot_m1, slot_m2;
	logic              pslot_q;

	logic           acc, last_col_in, last_row_in;
	logic [HA_W-1:0] lead_addr, top_addr, wr_haddr;
	logic [PA_W-1:0] pm_addr, wr_paddr;

	logic signed [H_W-1:0] lead_s1, top_s1, pmid_s1, h_s1, p_s1;
	logic signed [H_W-1:0] hist1_q, hist2_q, phist1_q, mid_q, left_q, mid_h;
	logic [RW-1:0]         row_s1;
	logic [CW-1:0]         col_s1;
	logic                  r_ge1_s1, r_ge2_s1, c_ge1_s1, c_ge2_s1, lcol_s1;
	logic [2:0]            pend_s1, pick, pend_left;

	logic                  issue, credit_ok, pop;
	job_t                  job;
	logic                  res_vld;
	res_t                  res;

	logic [OCC_W-1:0]      occ_q, fcnt_q;
	logic [PTR_W-1:0]      wptr_q, rptr_q;
	res_t                  fifo_q [FIFO_DEPTH];
	res_t                  head;

	assign acc         = s_tvalid && s_tready;
	assign last_col_in = (col_q == last_col_q);
	assign last_row_in = (row_q == last_row_q);

	// Row r-1 sits two slots on, row r-2 one slot on.
	assign slot_m1 = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
	assign slot_m2 = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;

	// The lead read fetches the right neighbour of the row above; on a row's
	// last column it fetches column 0 of this row for the next row's start.
	assign lead_addr = last_col_in ? haddr(slot_q, '0) : haddr(slot_m1, col_q + CW'(1));
	assign top_addr  = haddr(slot_m2, col_q);
	assign wr_haddr  = haddr(slot_q, col_q);
	assign pm_addr   = (pslot_q ? '0 : PSTRIDE) + PA_W'(col_q);
	assign wr_paddr  = (pslot_q ? PSTRIDE : '0) + PA_W'(col_q);

	always_ff @(posedge clk) begin
		if (acc) begin
			hmem[wr_haddr] <= s_tdata[31:0];
			pmem[wr_paddr] <= s_tdata[63:32];
			lead_s1        <= hmem[lead_addr];
			top_s1         <= hmem[top_addr];
			pmid_s1        <= pmem[pm_addr];
		end
	end

	// Input stage and the column history around it.
	always_ff @(posedge clk) begin
		if (acc) begin
			h_s1     <= s_tdata[31:0];
			p_s1     <= s_tdata[63:32];
			hist1_q  <= h_s1;
			hist2_q  <= hist1_q;
			phist1_q <= p_s1;
			mid_q    <= lead_s1;
			left_q   <= mid_q;
			row_s1   <= row_q;
			col_s1   <= col_q;
			r_ge1_s1 <= (row_q != '0);
			r_ge2_s1 <= (row_q > RW'(1));
			c_ge1_s1 <= (col_q != '0);
			c_ge2_s1 <= (col_q > CW'(1));
			lcol_s1  <= last_col_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= RW'(clamp_last(9'(ROWS_RESET), MAX_ROWS));
			last_col_q <= CW'(clamp_last(9'(COLS_RESET), MAX_COLS));
			beta_q     <= BETA_RESET;
			gain_q     <= GAIN_RESET;
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= 2'd0;
			pslot_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS: begin
					last_row_q <= RW'(clamp_last(cfg_data[8:0], MAX_ROWS));
					row_q      <= '0;
					col_q      <= '0;
					slot_q     <= 2'd0;
					pslot_q    <= 1'b0;
				end
				REG_COLS: begin
					last_col_q <= CW'(clamp_last(cfg_data[8:0], MAX_COLS));
					row_q      <= '0;
					col_q      <= '0;
					slot_q     <= 2'd0;
					pslot_q    <= 1'b0;
				end
				REG_BETA: beta_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data;
			endcase
		end else if (acc) begin
			if (!last_col_in) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				if (last_row_in) begin
					row_q   <= '0;
					slot_q  <= 2'd0;
					pslot_q <= 1'b0;
				end else begin
					row_q   <= row_q + RW'(1);
					slot_q  <= slot_m2;
					pslot_q <= !pslot_q;
				end
			end
		end
	end

	// Pending updates of the cell in the input stage, in output order:
	// bit 0 the cell above, bit 1 the last-row cell to the left, bit 2 the
	// grid's final cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 3'b000;
		end else if (acc) begin
			pend_s1 <= {last_row_in && last_col_in,
				last_row_in && (col_q != '0),
				row_q != '0};
		end else if (issue) begin
			pend_s1 <= pend_left;
		end
	end

	assign credit_ok = (occ_q < OCC_W'(FIFO_DEPTH));
	assign issue     = (pend_s1 != 3'b000) && credit_ok;
	assign pick      = {pend_s1[2] && !pend_s1[1] && !pend_s1[0],
		pend_s1[1] && !pend_s1[0], pend_s1[0]};
	assign pend_left = pend_s1 & ~(issue ? pick : 3'b000);
	assign s_tready  = (pend_left == 3'b000);

	// With a single column the cell above is simply the previous transaction.
	assign mid_h = (last_col_q == '0) ? hist1_q : mid_q;

	always_comb begin
		if (pick[0]) begin
			job = make_job(mid_h, left_q, c_ge1_s1, lead_s1, !lcol_s1, top_s1, r_ge2_s1,
				h_s1, 1'b1, pmid_s1, 8'(row_s1 - RW'(1)), 8'(col_s1), 1'b0);
		end else if (pick[1]) begin
			job = make_job(hist1_q, hist2_q, c_ge2_s1, h_s1, 1'b1, left_q, r_ge1_s1,
				h_s1, 1'b0, phist1_q, 8'(row_s1), 8'(col_s1 - CW'(1)), 1'b0);
		end else begin
			job = make_job(h_s1, hist1_q, c_ge1_s1, h_s1, 1'b0, mid_h, r_ge1_s1,
				h_s1, 1'b0, p_s1, 8'(row_s1), 8'(col_s1), 1'b1);
		end
	end

	whss_calc u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_vld (issue),
		.job     (job),
		.beta    (beta_q),
		.gain    (gain_q),
		.res_vld (res_vld),
		.res     (res)
	);

	// Output queue; occ_q counts slots reserved by updates in flight or queued.
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			fcnt_q <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (issue && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (!issue && pop) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (res_vld && !pop) begin
				fcnt_q <= fcnt_q + OCC_W'(1);
			end else if (!res_vld && pop) begin
				fcnt_q <= fcnt_q - OCC_W'(1);
			end
			if (res_vld) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			fifo_q[wptr_q] <= res;
		end
	end

	assign head     = fifo_q[rptr_q];
	assign m_tvalid = (fcnt_q != '0);
	assign m_tdata  = {head.col, head.row, head.height};
	assign m_tlast  = head.done;

	a_credit_covers_queue: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= occ_q)
		else $error("output queue holds more results than reserved slots");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (fcnt_q != OCC_W'(FIFO_DEPTH)))
		else $error("result written into a full output queue");

	a_hold_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 != 3'b000 && !issue) |-> !s_tready)
		else $error("input taken while the previous cell still has updates");

	a_grid_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_row_in && last_col_in && !cfg_write) |=>
			(row_q == '0 && col_q == '0 && slot_q == 2'd0 && !pslot_q))
		else $error("position did not wrap after the grid's last cell");

endmodule

`default_nettype wire

[sv/whss_calc.sv]
// Arithmetic pipeline: five-point laplacian, damping term, rounding and saturation.
`default_nettype none

module whss_calc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_vld,
	input  whss_pkg::job_t               job,
	input  logic [whss_pkg::COEF_W-1:0]  beta,
	input  logic [whss_pkg::COEF_W-1:0]  gain,
	output logic                         res_vld,
	output whss_pkg::res_t               res
);
	import whss_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	job_t job_s1;

	logic signed [32:0] sum01_s2, sum23_s2, diff_s2;
	logic signed [34:0] hmul_s2;
	logic signed [31:0] h_s2, h_s3, h_s4;
	logic signed [35:0] lap_s3;
	logic signed [32:0] diff_s3;
	logic signed [52:0] gterm_s4;
	logic signed [49:0] bterm_s4;
	logic signed [53:0] acc_s5;

	logic [POS_W-1:0] row_s2, row_s3, row_s4, row_s5;
	logic [POS_W-1:0] col_s2, col_s3, col_s4, col_s5;
	logic             done_s2, done_s3, done_s4, done_s5;

	logic signed [16:0] gain_x, beta_x;
	logic signed [34:0] hmul;
	logic signed [37:0] quo;

	assign gain_x = {1'b0, gain};
	assign beta_x = {1'b0, beta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= job_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// The centre weight is minus the number of neighbours present.
	always_comb begin
		case (job_s1.nb_cnt)
			3'd0:    hmul = '0;
			3'd1:    hmul = 35'(job_s1.h);
			3'd2:    hmul = 35'(job_s1.h) <<< 1;
			3'd3:    hmul = (35'(job_s1.h) <<< 1) + 35'(job_s1.h);
			default: hmul = 35'(job_s1.h) <<< 2;
		endcase
	end

	always_ff @(posedge clk) begin
		job_s1   <= job;

		sum01_s2 <= 33'(job_s1.nb_l) + 33'(job_s1.nb_r);
		sum23_s2 <= 33'(job_s1.nb_u) + 33'(job_s1.nb_d);
		hmul_s2  <= hmul;
		diff_s2  <= 33'(job_s1.h) - 33'(job_s1.prev);
		h_s2     <= job_s1.h;
		row_s2   <= job_s1.row;
		col_s2   <= job_s1.col;
		done_s2  <= job_s1.done;

		lap_s3   <= 36'(sum01_s2) + 36'(sum23_s2) - 36'(hmul_s2);
		diff_s3  <= diff_s2;
		h_s3     <= h_s2;
		row_s3   <= row_s2;
		col_s3   <= col_s2;
		done_s3  <= done_s2;

		gterm_s4 <= gain_x * lap_s3;
		bterm_s4 <= beta_x * diff_s3;
		h_s4     <= h_s3;
		row_s4   <= row_s3;
		col_s4   <= col_s3;
		done_s4  <= done_s3;

		acc_s5   <= {{6{h_s4[31]}}, h_s4, 16'd0} + 54'(gterm_s4) + 54'(bterm_s4)
			+ 54'sd32768;
		row_s5   <= row_s4;
		col_s5   <= col_s4;
		done_s5  <= done_s4;
	end

	// Arithmetic shift after the half-LSB offset gives round to nearest, ties up.
	assign quo = acc_s5[53:16];

	always_comb begin
		res.row  = row_s5;
		res.col  = col_s5;
		res.done = done_s5;
		if (quo[37:31] == 7'b0000000 || quo[37:31] == 7'b1111111) begin
			res.height = quo[31:0];
		end else if (quo[37]) begin
			res.height = 32'h8000_0000;
		end else begin
			res.height = 32'h7fff_ffff;
		end
	end

	assign res_vld = vld_s5;

endmodule

`default_nettype wire
